### rtl/core/mbr_pkg.sv
`timescale 1ns / 1ps

package mbr_pkg;

  // buffer geometry
  localparam int BUF_BYTES = 4096;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int LEN_W     = ADDR_W + 1;        // holds 0..BUF_BYTES
  localparam int POS_W     = LEN_W + 3;         // bit position
  localparam int WIN_BYTES = 5;                 // 32 bits at any bit offset
  localparam int WIN_W     = WIN_BYTES * 8;
  localparam int NB_W      = $clog2(WIN_BYTES + 1);
  localparam int MAX_BITS  = 32;

  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [7:0] BIT_MASK  = 8'h01;

  typedef enum logic [3:0] {
    FN_LOAD       = 4'd0,
    FN_READ_BITS  = 4'd1,
    FN_READ_BIT   = 4'd2,
    FN_READ_BYTE  = 4'd3,
    FN_READ_U32   = 4'd4,
    FN_READ_U16   = 4'd5,
    FN_ALIGN      = 4'd6,
    FN_SET_OFFSET = 4'd7,
    FN_ADD_OFFSET = 4'd8,
    FN_SET_BITPOS = 4'd9,
    FN_PEEK       = 4'd10,
    FN_PEEK_ARITH = 4'd11
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FIN
  } state_t;

  // clamp a byte offset to the effective length
  function automatic logic [LEN_W-1:0] clamp_len(input logic [31:0] v,
                                                  input logic [LEN_W-1:0] len);
    logic [31:0] len_ext;
    len_ext = {{(32-LEN_W){1'b0}}, len};
    return (v < len_ext) ? v[LEN_W-1:0] : len;
  endfunction

endpackage

### rtl/core/msb_first_bit_reader.sv
`timescale 1ns / 1ps
// MSB-first bit reader over a 4096-byte buffer.
// Input words (s_*): s_tuser carries the operation code; s_tdata carries the
// bit count, the operand (load address, offset, delta or bit position) and
// the byte to load. Each input word yields exactly one output word (m_*):
// m_tdata carries the data read and the cursor state after the operation,
// m_tuser the error flag. The buffer is loaded with load operations, one byte
// each; the stream length register is written through cfg_we/cfg_wdata, and
// the user must write it only while the block is idle; the block itself does
// not enforce this. A word passes through accept, one fetch per buffer byte,
// the capture of the last byte and finish; cursor moves and loads fetch no
// bytes, single-byte reads one, a 32-bit word four and a 32-bit bit read
// that straddles five bytes all five. Only one word is worked on at a time;
// the byte-wide buffer RAM is read one byte per cycle.
// Reset (rst, synchronous) clears the cursors, the length and the output
// stage; the buffer contents are kept and are undefined until loaded.
// A stalled receiver holds the result in the output register; a following
// word is still accepted and worked on, and waits in the finish state until
// the output register frees.

module msb_first_bit_reader (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // bit_count[5:0], operand_value[37:6], load_byte[45:38], 0
  input  logic [3:0]  s_tuser,  // func[3:0]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // result_data[31:0], byte_position[44:32],
                                // bit_in_byte[47:45], bytes_left[60:48], 0
  output logic [0:0]  m_tuser,  // status[0]
  // stream length register
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);

  localparam int LEN_W = mbr_pkg::LEN_W;
  localparam int POS_W = mbr_pkg::POS_W;
  localparam int NB_W  = mbr_pkg::NB_W;
  localparam int WIN_W = mbr_pkg::WIN_W;

  // state
  mbr_pkg::state_t state, state_next;
  logic [LEN_W-1:0] stream_length;
  logic [LEN_W-1:0] byte_cursor;
  logic [2:0]       bit_cursor;

  // latched operation
  mbr_pkg::func_t   fn;
  logic [5:0]       cnt;
  logic [31:0]      opv;
  logic [NB_W-1:0]  nbytes;
  logic [NB_W-1:0]  issue_cnt;
  logic [NB_W-1:0]  cap_cnt;
  logic             rd_pend;
  logic [WIN_W-1:0] win;

  // output register
  logic        out_valid;
  logic [63:0] out_data;
  logic        out_status;

  logic                       accept;
  logic                       fin_load;
  logic                       ram_re;
  logic                       ram_we;
  logic [7:0]                 ram_rdata;
  logic [LEN_W-1:0]           rd_addr;
  logic [LEN_W-1:0]           len;
  mbr_pkg::func_t             in_fn;
  logic [5:0]                 in_cnt;
  logic [31:0]                in_opv;
  logic [NB_W-1:0]            in_nbytes;
  logic [6:0]                 bits_span;

  // finish-stage results
  logic [31:0]      res;
  logic             err;
  logic [LEN_W-1:0] cur_new;
  logic [2:0]       bit_new;
  logic [LEN_W-1:0] left_new;

  assign in_fn  = mbr_pkg::func_t'(s_tuser[3:0]);
  assign in_opv = s_tdata[37:6];
  assign in_cnt = (s_tdata[5:0] > 6'(mbr_pkg::MAX_BITS)) ? 6'(mbr_pkg::MAX_BITS) : s_tdata[5:0];

  // bytes a bit read touches: ceil((bit offset + count) / 8)
  assign bits_span = 7'(bit_cursor) + 7'(in_cnt) + 7'd7;

  always_comb begin
    case (in_fn)
      mbr_pkg::FN_READ_BITS:  in_nbytes = NB_W'(bits_span[6:3]);
      mbr_pkg::FN_READ_BIT,
      mbr_pkg::FN_READ_BYTE,
      mbr_pkg::FN_PEEK:       in_nbytes = NB_W'(1);
      mbr_pkg::FN_READ_U32:   in_nbytes = NB_W'(4);
      mbr_pkg::FN_READ_U16,
      mbr_pkg::FN_PEEK_ARITH: in_nbytes = NB_W'(2);
      default:                in_nbytes = '0;
    endcase
  end

  assign len = (stream_length > LEN_W'(mbr_pkg::BUF_BYTES)) ?
               LEN_W'(mbr_pkg::BUF_BYTES) : stream_length;

  assign accept = s_tvalid & s_tready;

  // loads go straight into the buffer on accept; no read is in flight then
  assign ram_we  = accept && (in_fn == mbr_pkg::FN_LOAD) &&
                   (in_opv[31:mbr_pkg::ADDR_W] == '0);
  assign rd_addr = byte_cursor + LEN_W'(issue_cnt);

  mbr_ram #(
    .WIDTH(8),
    .DEPTH(mbr_pkg::BUF_BYTES)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_opv[mbr_pkg::ADDR_W-1:0]),
    .wdata(s_tdata[45:38]),
    .re   (ram_re),
    .raddr(rd_addr[mbr_pkg::ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  // sequencer
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_re     = 1'b0;
    fin_load   = 1'b0;
    case (state)
      mbr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (in_nbytes == '0) ? mbr_pkg::ST_FIN : mbr_pkg::ST_READ;
        end
      end
      mbr_pkg::ST_READ: begin
        ram_re = (issue_cnt < nbytes);
        if (rd_pend && (cap_cnt + NB_W'(1) == nbytes)) begin
          state_next = mbr_pkg::ST_FIN;
        end
      end
      mbr_pkg::ST_FIN: begin
        if (!out_valid || m_tready) begin
          fin_load   = 1'b1;
          state_next = mbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mbr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operation latch and byte window
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      cap_cnt   <= '0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= ram_re;
      if (accept) begin
        issue_cnt <= '0;
        cap_cnt   <= '0;
      end else begin
        if (ram_re) begin
          issue_cnt <= issue_cnt + NB_W'(1);
        end
        if (rd_pend) begin
          cap_cnt <= cap_cnt + NB_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fn     <= in_fn;
      cnt    <= in_cnt;
      opv    <= in_opv;
      nbytes <= in_nbytes;
      win    <= '0;
    end else if (rd_pend) begin
      // first byte fetched lands in the top of the window
      win[WIN_W - 1 - 8 * int'(cap_cnt) -: 8] <= ram_rdata;
    end
  end

  // finish stage: result and cursor update from the gathered bytes
  always_comb begin
    logic             inb;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] avail;
    logic [POS_W-1:0] pos_new;
    logic [5:0]       n;
    logic [WIN_W-1:0] sh;
    logic [31:0]      top;
    logic [LEN_W:0]   cur_p1;
    logic [LEN_W:0]   cur_p3;
    logic [32:0]      sum;
    logic [7:0]       pk_cur;
    logic [7:0]       pk_nxt;

    inb     = (byte_cursor < len);
    pos     = {byte_cursor, bit_cursor};
    avail   = {len, 3'b000} - pos;
    n       = (POS_W'(cnt) < avail) ? cnt : avail[5:0];
    sh      = win << bit_cursor;
    top     = sh[WIN_W-1 -: 32];
    cur_p1  = {1'b0, byte_cursor} + (LEN_W+1)'(1);
    cur_p3  = {1'b0, byte_cursor} + (LEN_W+1)'(3);
    sum     = {1'b0, opv} + 33'(byte_cursor);
    pk_cur  = inb ? win[WIN_W-1 -: 8] : mbr_pkg::FILL_BYTE;
    pk_nxt  = (cur_p1 < {1'b0, len}) ? win[WIN_W-9 -: 8] : mbr_pkg::FILL_BYTE;
    pos_new = pos;

    res     = '0;
    err     = 1'b0;
    cur_new = byte_cursor;
    bit_new = bit_cursor;

    case (fn)
      mbr_pkg::FN_LOAD: begin
        err = (opv[31:mbr_pkg::ADDR_W] != '0);
      end
      mbr_pkg::FN_READ_BITS: begin
        if (!inb) begin
          err = 1'b1;
        end else begin
          res     = top >> (6'd32 - n);
          pos_new = pos + POS_W'(n);
          cur_new = pos_new[POS_W-1:3];
          bit_new = pos_new[2:0];
        end
      end
      mbr_pkg::FN_READ_BIT: begin
        if (!inb) begin
          err = 1'b1;
        end else begin
          res     = 32'(sh[WIN_W-1] & mbr_pkg::BIT_MASK[0]);
          pos_new = pos + POS_W'(1);
          cur_new = pos_new[POS_W-1:3];
          bit_new = pos_new[2:0];
        end
      end
      mbr_pkg::FN_READ_BYTE: begin
        if (!inb) begin
          err = 1'b1;
        end else begin
          res     = 32'(win[WIN_W-1 -: 8]);
          cur_new = cur_p1[LEN_W-1:0];
        end
      end
      mbr_pkg::FN_READ_U32: begin
        if (cur_p3 >= {1'b0, len}) begin
          err = 1'b1;
        end else begin
          res     = win[WIN_W-1 -: 32];
          cur_new = byte_cursor + LEN_W'(4);
        end
      end
      mbr_pkg::FN_READ_U16: begin
        if (cur_p1 >= {1'b0, len}) begin
          err = 1'b1;
        end else begin
          res     = 32'(win[WIN_W-1 -: 16]);
          cur_new = byte_cursor + LEN_W'(2);
        end
      end
      mbr_pkg::FN_ALIGN: begin
        if (bit_cursor != 3'd0) begin
          cur_new = mbr_pkg::clamp_len(32'(cur_p1), len);
          bit_new = 3'd0;
        end
      end
      mbr_pkg::FN_SET_OFFSET: begin
        cur_new = mbr_pkg::clamp_len(opv, len);
      end
      mbr_pkg::FN_ADD_OFFSET: begin
        // a sum that overflows 32 bits leaves the cursor alone
        if (!sum[32]) begin
          cur_new = mbr_pkg::clamp_len(sum[31:0], len);
        end
      end
      mbr_pkg::FN_SET_BITPOS: begin
        cur_new = mbr_pkg::clamp_len({3'b000, opv[31:3]}, len);
        bit_new = opv[2:0];
      end
      mbr_pkg::FN_PEEK: begin
        res = inb ? 32'(win[WIN_W-1 -: 8]) : '0;
      end
      mbr_pkg::FN_PEEK_ARITH: begin
        res = {16'h0000, pk_nxt, pk_cur};
      end
      default: begin
        err = 1'b1;
      end
    endcase

    left_new = (len > cur_new) ? (len - cur_new) : '0;
  end

  // cursors and length register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cursor   <= '0;
      bit_cursor    <= '0;
      stream_length <= '0;
    end else begin
      if (cfg_we) begin
        stream_length <= cfg_wdata;
      end
      if (fin_load) begin
        byte_cursor <= cur_new;
        bit_cursor  <= bit_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fin_load | (out_valid & ~m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_data   <= {3'b000, left_new, bit_new, cur_new, res};
      out_status <= err;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_data;
  assign m_tuser[0] = out_status;

`ifndef SYNTHESIS
  // an error result never carries data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[31:0] == 32'd0))
    else $error("error result with nonzero data");

  // a finished item waits while the output register is held
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == mbr_pkg::ST_FIN && out_valid && !m_tready) |=>
      (state == mbr_pkg::ST_FIN))
    else $error("finish stage overwrote a held result");

  // bytes captured never run ahead of bytes fetched
  a_cap_order: assert property (@(posedge clk) disable iff (rst)
    (state == mbr_pkg::ST_READ) |-> (cap_cnt <= issue_cnt))
    else $error("capture ahead of fetch");

  // byte cursor stays within the buffer
  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    byte_cursor <= LEN_W'(mbr_pkg::BUF_BYTES))
    else $error("byte cursor beyond buffer");
`endif

endmodule

### rtl/core/mbr_ram.sv
`timescale 1ns / 1ps

module mbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sim/msb_first_bit_reader_tb.sv
`timescale 1ns / 1ps

module testbench;
  import mbr_pkg::*;

  // codes outside the defined operation set
  localparam logic [3:0] FN_UNUSED_FIRST = 4'd12;
  localparam logic [3:0] FN_UNUSED_LAST  = 4'd15;

  localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
  localparam int SETTLE_WAIT  = 16;    // pause at the end
  localparam int SEGMENTS     = 5;     // length settings per idling phase
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    logic [31:0] data;
    logic        status;
    logic [12:0] byte_pos;
    logic [2:0]  bit_pos;
    logic [12:0] left;
  } reader_result_t;

  // directed rows: checked against the shadow reader, checked against a
  // typed-in answer, or a write of the length register
  typedef enum logic [1:0] {
    RK_PREDICT,
    RK_TYPED,
    RK_LENGTH
  } row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [12:0]    length;
    logic [3:0]     func;
    logic [5:0]     cnt;
    logic [31:0]    op;
    logic [7:0]     lb;
    reader_result_t answer;
  } dir_row_t;

  localparam reader_result_t NO_TYPED     = '0;
  localparam reader_result_t OK_AT_START  = '{32'd0, 1'b0, 13'd0, 3'd0, 13'd0};
  localparam reader_result_t ERR_AT_START = '{32'd0, 1'b1, 13'd0, 3'd0, 13'd0};
  localparam reader_result_t FILL_AT_START = '{32'h0000_FFFF, 1'b0, 13'd0, 3'd0, 13'd0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // bit_count[5:0], operand_value[37:6], load_byte[45:38], 0
  logic [3:0]  s_tuser = '0;   // func[3:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // result_data[31:0], byte_position[44:32],
                               // bit_in_byte[47:45], bytes_left[60:48], 0
  logic [0:0]  m_tuser;        // status[0]
  logic        cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;

  msb_first_bit_reader u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow reader: own copy of the buffer, the cursors and the length
  // ---------------------------------------------------------------------
  logic [7:0]  shadow_buf [BUF_BYTES];
  int unsigned cur_byte = 0;
  int unsigned cur_bit  = 0;
  logic [12:0] len_reg  = '0;

  reader_result_t results_due [$];   // one per accepted input word, oldest first
  int unsigned    mismatches  = 0;
  int unsigned    tx_idle_pct = 7;
  int unsigned    rx_idle_pct = 67;

  // register value beyond the buffer size reads as the buffer size
  function automatic int unsigned live_length();
    return (len_reg < BUF_BYTES) ? int'(len_reg) : BUF_BYTES;
  endfunction

  function automatic int unsigned clamp_to_len(input logic [63:0] v);
    int unsigned lim;
    lim = live_length();
    return (v < 64'(lim)) ? int'(v[31:0]) : lim;
  endfunction

  // bit under the cursor, bit 0 of the cursor being the MSB of the byte
  function automatic logic cursor_bit();
    return shadow_buf[cur_byte][7 - cur_bit];
  endfunction

  function automatic void step_bit();
    if (cur_bit == 7) begin
      cur_byte++;
      cur_bit = 0;
    end else begin
      cur_bit++;
    end
  endfunction

  function automatic reader_result_t reader_step_result(input logic [3:0] func,
                                                        input logic [5:0] cnt,
                                                        input logic [31:0] op,
                                                        input logic [7:0] lb);
    reader_result_t r;
    int unsigned    lim;
    int unsigned    n;
    int unsigned    avail;
    bit             inb;
    logic [7:0]     here;
    logic [7:0]     next_b;
    logic [63:0]    sum;
    lim = live_length();
    inb = cur_byte < lim;
    r = '0;
    case (func)
      FN_LOAD: begin
        if (op < BUF_BYTES) shadow_buf[op[ADDR_W-1:0]] = lb;
        else r.status = 1'b1;
      end
      FN_READ_BITS: begin
        if (!inb) begin
          r.status = 1'b1;
        end else begin
          // count clamps to 32, then to what is left; still status ok
          avail = lim * 8 - (cur_byte * 8 + cur_bit);
          n = (cnt > MAX_BITS) ? MAX_BITS : cnt;
          if (n > avail) n = avail;
          repeat (n) begin
            r.data = {r.data[30:0], cursor_bit()};
            step_bit();
          end
        end
      end
      FN_READ_BIT: begin
        if (!inb) begin
          r.status = 1'b1;
        end else begin
          r.data = {31'd0, cursor_bit()};
          step_bit();
        end
      end
      FN_READ_BYTE: begin
        if (!inb) begin
          r.status = 1'b1;
        end else begin
          r.data = {24'd0, shadow_buf[cur_byte]};
          cur_byte++;
        end
      end
      FN_READ_U32: begin
        if (cur_byte + 3 >= lim) begin
          r.status = 1'b1;
        end else begin
          r.data = {shadow_buf[cur_byte], shadow_buf[cur_byte + 1],
                    shadow_buf[cur_byte + 2], shadow_buf[cur_byte + 3]};
          cur_byte += 4;
        end
      end
      FN_READ_U16: begin
        if (cur_byte + 1 >= lim) begin
          r.status = 1'b1;
        end else begin
          r.data = {16'd0, shadow_buf[cur_byte], shadow_buf[cur_byte + 1]};
          cur_byte += 2;
        end
      end
      FN_ALIGN: begin
        if (cur_bit != 0) begin
          cur_byte = clamp_to_len(64'(cur_byte) + 64'd1);
          cur_bit = 0;
        end
      end
      FN_SET_OFFSET: cur_byte = clamp_to_len(64'(op));
      FN_ADD_OFFSET: begin
        // a move that overflows 32 bits is dropped
        sum = 64'(cur_byte) + 64'(op);
        if (sum <= 64'hFFFF_FFFF) cur_byte = clamp_to_len(sum);
      end
      FN_SET_BITPOS: begin
        cur_byte = clamp_to_len(64'(op >> 3));
        cur_bit = op[2:0];
      end
      FN_PEEK: r.data = inb ? {24'd0, shadow_buf[cur_byte]} : 32'd0;
      FN_PEEK_ARITH: begin
        here   = inb ? shadow_buf[cur_byte] : FILL_BYTE;
        next_b = (cur_byte + 1 < lim) ? shadow_buf[cur_byte + 1] : FILL_BYTE;
        r.data = {16'd0, next_b, here};
      end
      default: r.status = 1'b1;
    endcase
    r.byte_pos = cur_byte[12:0];
    r.bit_pos  = cur_bit[2:0];
    r.left     = (lim > cur_byte) ? 13'(lim - cur_byte) : 13'd0;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  task automatic idle_gap();
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // present one word, wait for it to be taken, then book its result;
  // tvalid is left high so a following word can go straight after
  task automatic send_word(input logic [3:0] func, input logic [5:0] cnt,
                           input logic [31:0] op, input logic [7:0] lb,
                           input bit typed, input reader_result_t typed_res);
    reader_result_t due;
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {2'b00, lb, op, cnt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due = reader_step_result(func, cnt, op, lb);
    results_due.push_back(typed ? typed_res : due);
  endtask

  // length register only changes with nothing in flight
  task automatic write_length(input logic [12:0] value);
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    len_reg = value;
  endtask

  task automatic send_random_word();
    logic [3:0]  func;
    logic [5:0]  cnt;
    logic [31:0] op;
    logic [7:0]  lb;
    int unsigned pick;
    pick = $urandom_range(99);
    if      (pick < 8)  func = FN_LOAD;
    else if (pick < 28) func = FN_READ_BITS;
    else if (pick < 36) func = FN_READ_BIT;
    else if (pick < 44) func = FN_READ_BYTE;
    else if (pick < 52) func = FN_READ_U32;
    else if (pick < 60) func = FN_READ_U16;
    else if (pick < 66) func = FN_ALIGN;
    else if (pick < 74) func = FN_SET_OFFSET;
    else if (pick < 80) func = FN_ADD_OFFSET;
    else if (pick < 88) func = FN_SET_BITPOS;
    else if (pick < 93) func = FN_PEEK;
    else if (pick < 98) func = FN_PEEK_ARITH;
    else                func = 4'($urandom_range(FN_UNUSED_LAST, FN_UNUSED_FIRST));
    cnt = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(MAX_BITS));
    op  = $urandom();
    lb  = 8'($urandom_range(255));
    // operands mostly near the live stream, now and then anything at all
    case (func)
      FN_LOAD:       if ($urandom_range(9) != 0) op = $urandom_range(BUF_BYTES - 1);
      FN_SET_OFFSET: if ($urandom_range(7) != 0) op = $urandom_range(live_length() + 4);
      FN_ADD_OFFSET: if ($urandom_range(7) != 0) op = $urandom_range(12);
      FN_SET_BITPOS: if ($urandom_range(7) != 0) op = $urandom_range(live_length() * 8 + 15);
      default: ;
    endcase
    send_word(func, cnt, op, lb, 1'b0, NO_TYPED);
  endtask

  function automatic logic [12:0] pick_length(input int unsigned phase, input int unsigned seg);
    if (seg == 0 && phase == 0) return 13'h1FFF;     // above the buffer size
    if (seg == 0 && phase == 1) return 13'(BUF_BYTES);
    case ($urandom_range(5))
      0:       return 13'd0;
      1:       return 13'(BUF_BYTES);
      2:       return 13'h1FFF;
      3:       return 13'($urandom_range(16, 1));
      4:       return 13'($urandom_range(300, 17));
      default: return 13'($urandom_range(13'h1FFF));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  dir_row_t dir_rows [32];

  initial begin : stimulus
    int unsigned n_items;
    dir_rows = '{
      // straight after reset: length 0, cursors at the origin
      '{RK_TYPED,   13'd0, FN_READ_BIT,     6'd0,  32'd0,         8'h00, ERR_AT_START},
      '{RK_TYPED,   13'd0, FN_READ_BITS,    6'd0,  32'd0,         8'h00, ERR_AT_START},
      '{RK_TYPED,   13'd0, FN_READ_U32,     6'd0,  32'd0,         8'h00, ERR_AT_START},
      '{RK_TYPED,   13'd0, FN_PEEK,         6'd0,  32'd0,         8'h00, OK_AT_START},
      '{RK_TYPED,   13'd0, FN_PEEK_ARITH,   6'd0,  32'd0,         8'h00, FILL_AT_START},
      '{RK_TYPED,   13'd0, FN_UNUSED_FIRST, 6'd0,  32'd0,         8'h00, ERR_AT_START},
      '{RK_TYPED,   13'd0, FN_UNUSED_LAST,  6'h3F, 32'hFFFF_FFFF, 8'hFF, ERR_AT_START},
      // loads past the buffer store nothing; then bytes 0 to 4 are loaded
      '{RK_TYPED,   13'd0, FN_LOAD,         6'd0,  32'd4096,      8'hFF, ERR_AT_START},
      '{RK_TYPED,   13'd0, FN_LOAD,         6'd0,  32'hFFFF_FFFF, 8'h00, ERR_AT_START},
      '{RK_TYPED,   13'd0, FN_LOAD,         6'd0,  32'd0,         8'hFF, OK_AT_START},
      '{RK_PREDICT, 13'd0, FN_LOAD,         6'd0,  32'd1,         8'h00, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_LOAD,         6'd0,  32'd2,         8'h80, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_LOAD,         6'd0,  32'd3,         8'h01, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_LOAD,         6'd0,  32'd4,         8'hA5, NO_TYPED},
      '{RK_LENGTH,  13'd5, FN_LOAD,         6'd0,  32'd0,         8'h00, NO_TYPED},
      // word reads, the second one short of bytes
      '{RK_PREDICT, 13'd0, FN_READ_U32,     6'd0,  32'd0,         8'h00, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_READ_U16,     6'd0,  32'd0,         8'h00, NO_TYPED},
      // bit position far beyond the end saturates, then align at the end
      '{RK_PREDICT, 13'd0, FN_SET_BITPOS,   6'd0,  32'hFFFF_FFFF, 8'h00, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_ALIGN,        6'd0,  32'd0,         8'h00, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_SET_OFFSET,   6'd0,  32'd0,         8'h00, NO_TYPED},
      // count above 32, then a read running off the end
      '{RK_PREDICT, 13'd0, FN_READ_BITS,    6'h3F, 32'd0,         8'h00, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_READ_BITS,    6'd32, 32'd0,         8'h00, NO_TYPED},
      // delta that overflows 32 bits leaves the cursor alone
      '{RK_PREDICT, 13'd0, FN_ADD_OFFSET,   6'd0,  32'hFFFF_FFFF, 8'h00, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_SET_BITPOS,   6'd0,  32'd3,         8'h00, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_READ_BYTE,    6'd0,  32'd0,         8'h00, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_PEEK_ARITH,   6'd0,  32'd0,         8'h00, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_SET_OFFSET,   6'd0,  32'd4,         8'h00, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_PEEK_ARITH,   6'd0,  32'd0,         8'h00, NO_TYPED},
      // length cut below the cursor
      '{RK_LENGTH,  13'd2, FN_LOAD,         6'd0,  32'd0,         8'h00, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_PEEK,         6'd0,  32'd0,         8'h00, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_READ_BITS,    6'd8,  32'd0,         8'h00, NO_TYPED},
      '{RK_PREDICT, 13'd0, FN_ALIGN,        6'd0,  32'd0,         8'h00, NO_TYPED}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RK_LENGTH) begin
        write_length(dir_rows[i].length);
      end else begin
        idle_gap();
        send_word(dir_rows[i].func, dir_rows[i].cnt, dir_rows[i].op, dir_rows[i].lb,
                  dir_rows[i].kind == RK_TYPED, dir_rows[i].answer);
      end
    end

    // fill the whole buffer so every later read lands on loaded bytes
    for (int a = 0; a < BUF_BYTES; a++) begin
      idle_gap();
      send_word(FN_LOAD, 6'($urandom_range(63)), 32'(a), 8'($urandom_range(255)),
                1'b0, NO_TYPED);
    end

    // three idling phases: sender light / receiver heavy, swapped, none
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 7;  rx_idle_pct = 67; end
        1:       begin tx_idle_pct = 67; rx_idle_pct = 7;  end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        write_length(pick_length(phase, seg));
        n_items = $urandom_range(32, 22);
        repeat (n_items) begin
          idle_gap();
          send_random_word();
        end
      end
    end

    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("msb_first_bit_reader test passed");
    end else begin
      $display("msb_first_bit_reader test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver side and result check
  // ---------------------------------------------------------------------
  task automatic flag_mismatch(input string msg);
    if (mismatches < SHOWN_ERRORS) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_check
    reader_result_t seen;
    reader_result_t want;
    string          bad;
    m_tready <= !rst && ($urandom_range(99) >= rx_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      seen = '{m_tdata[31:0], m_tuser[0], m_tdata[44:32], m_tdata[47:45], m_tdata[60:48]};
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("result word with none due, data %h status %0d",
                                seen.data, seen.status));
      end else begin
        want = results_due.pop_front();
        bad = "";
        if (seen.data     !== want.data)     bad = {bad, " data"};
        if (seen.status   !== want.status)   bad = {bad, " status"};
        if (seen.byte_pos !== want.byte_pos) bad = {bad, " byte_pos"};
        if (seen.bit_pos  !== want.bit_pos)  bad = {bad, " bit_pos"};
        if (seen.left     !== want.left)     bad = {bad, " left"};
        if (bad != "")
          flag_mismatch($sformatf(
            "%s: want data %h st %0d pos %0d.%0d left %0d, got data %h st %0d pos %0d.%0d left %0d",
            bad, want.data, want.status, want.byte_pos, want.bit_pos, want.left,
            seen.data, seen.status, seen.byte_pos, seen.bit_pos, seen.left));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: too long with no word moving on either side
  // ---------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("msb_first_bit_reader test failed");
      $finish;
    end
  end

endmodule
